/* src/quadratic_root_solver_core_defines.svh */
// Assertion macros shared by the solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define QRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define QRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/qrs_pkg.sv */
// Package with constants and codes of the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DISC_BITS  = 34;
  localparam int VAL_BITS   = 35;

  typedef enum logic [1:0] {
    CASE_TWO_REAL = 2'd0,
    CASE_DOUBLE   = 2'd1,
    CASE_COMPLEX  = 2'd2,
    CASE_LINEAR   = 2'd3
  } root_case_t;
endpackage
`default_nettype wire

/* src/qrs_stream_if.sv */
// Valid/ready stream interface carrying a generic payload.
`timescale 1ns / 1ps
`default_nettype none
interface qrs_stream_if #(
  parameter int WIDTH = 1
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/quadratic_root_solver_core.sv */
// Top level of the pipelined quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_root_solver_core_defines.svh"
// Takes one coefficient beat {a, b, c} per cycle on in_ch and returns one
// result beat {root_case, discriminant, first_value, second_value} on out_ch.
// The pipeline is 2 + SQ + 2 + DV + 1 stages deep, where SQ = COEF_WIDTH + 1 +
// FRAC_BITS is one stage per root digit pair and DV = SQ + 2 is one stage per
// quotient bit of the restoring dividers. Throughput is one beat per cycle
// while the output is not stalled. All stages advance
// together when the output slot is free or empty, so back pressure stalls
// the whole pipeline without loss. Roots are Q(FRAC_BITS); division truncates
// toward zero. Payload layout on in_ch.data: {coef_a, coef_b, coef_c};
// on out_ch.data: {root_case, discriminant, first_value, second_value}.
module quadratic_root_solver_core #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  qrs_stream_if.sink   in_ch,
  qrs_stream_if.source out_ch
);
  localparam int CW  = COEF_WIDTH;
  localparam int DB  = qrs_pkg::DISC_BITS;
  localparam int VB  = qrs_pkg::VAL_BITS;
  // discriminant magnitude fits 2CW+2 bits
  localparam int MW  = 2 * CW + 2;
  localparam int SQ  = CW + 1 + FRAC_BITS;
  localparam int RW  = SQ + 2;            // root remainder width
  localparam int NW  = SQ + 2;            // numerator magnitude width
  localparam int DW  = CW + 1;            // |2a| width
  localparam int DV  = NW;                // quotient bits
  localparam int QW  = NW;
  localparam int DMW = (MW > 2 * CW + 3) ? MW : 2 * CW + 3;

  // per-item context through the pipe
  typedef struct packed {
    logic [1:0]        rcase;
    logic signed [DMW-1:0] disc;
    logic [DW-1:0]     den;       // |2a|
    logic              neg_den;
    logic signed [CW-1:0] b;
  } ctx_t;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: products
  logic                   v1;
  logic signed [CW-1:0]   a1, b1;
  logic signed [2*CW-1:0] bb1, ac1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_ch.valid;
    if (adv) begin
      a1  <= in_ch.data[3*CW-1:2*CW];
      b1  <= in_ch.data[2*CW-1:CW];
      bb1 <= $signed(in_ch.data[2*CW-1:CW]) * $signed(in_ch.data[2*CW-1:CW]);
      ac1 <= $signed(in_ch.data[3*CW-1:2*CW]) * $signed(in_ch.data[CW-1:0]);
    end
  end

  // stage 2: discriminant and case
  logic v2;
  ctx_t c2;
  logic [MW-1:0] mag2;
  logic signed [DMW-1:0] d_w;
  assign d_w = DMW'(bb1) - (DMW'(ac1) <<< 2);
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      c2.disc    <= d_w;
      c2.b       <= b1;
      c2.neg_den <= a1[CW-1];
      c2.den     <= a1[CW-1] ? DW'(-(DW'(a1)) <<< 1) : (DW'(a1) <<< 1);
      mag2       <= d_w[DMW-1] ? MW'(-d_w) : MW'(d_w);
      if (a1 == '0)              c2.rcase <= qrs_pkg::CASE_LINEAR;
      else if (d_w == '0)        c2.rcase <= qrs_pkg::CASE_DOUBLE;
      else if (d_w[DMW-1])       c2.rcase <= qrs_pkg::CASE_COMPLEX;
      else                       c2.rcase <= qrs_pkg::CASE_TWO_REAL;
    end
  end

  // square root: one digit pair per stage
  logic            sv   [SQ+1];
  ctx_t            sc   [SQ+1];
  logic [MW-1:0]   smag [SQ+1];
  logic [RW-1:0]   srem [SQ+1];
  logic [SQ-1:0]   sroot[SQ+1];
  assign sv[0] = v2; assign sc[0] = c2; assign smag[0] = mag2;
  assign srem[0] = '0; assign sroot[0] = '0;
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    localparam int I = SQ - 1 - g;
    logic [1:0]    pair;
    logic [RW-1:0] rem_w, trial;
    if (I >= FRAC_BITS) begin : g_p
      assign pair = smag[g][2*(I-FRAC_BITS) +: 2];
    end else begin : g_z
      assign pair = 2'b00;
    end
    assign rem_w = {srem[g][RW-3:0], pair};
    assign trial = {sroot[g][RW-3:0], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) sv[g+1] <= 1'b0;
      else if (adv) sv[g+1] <= sv[g];
      if (adv) begin
        sc[g+1]   <= sc[g];
        smag[g+1] <= smag[g];
        if (rem_w >= trial) begin
          srem[g+1]  <= rem_w - trial;
          sroot[g+1] <= {sroot[g][SQ-2:0], 1'b1};
        end else begin
          srem[g+1]  <= rem_w;
          sroot[g+1] <= {sroot[g][SQ-2:0], 1'b0};
        end
      end
    end
  end

  // numerators: signed, then magnitude and sign of each quotient
  logic v3;
  ctx_t c3;
  logic signed [NW:0] n1_3, n2_3;
  logic signed [NW:0] nb_w, s_w;
  assign nb_w = -((NW+1)'(sc[SQ].b) <<< FRAC_BITS);
  assign s_w  = (NW+1)'({1'b0, sroot[SQ]});
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= sv[SQ];
    if (adv) begin
      c3 <= sc[SQ];
      case (sc[SQ].rcase)
        qrs_pkg::CASE_TWO_REAL: begin n1_3 <= nb_w + s_w; n2_3 <= nb_w - s_w; end
        qrs_pkg::CASE_COMPLEX:  begin n1_3 <= nb_w; n2_3 <= s_w; end
        default:                begin n1_3 <= nb_w; n2_3 <= nb_w; end
      endcase
    end
  end

  typedef struct packed {
    logic [NW-1:0] num;
    logic          neg;
  } qin_t;
  logic v4;
  ctx_t c4;
  qin_t q1_4, q2_4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      c4 <= c3;
      q1_4.num <= n1_3[NW] ? NW'(-n1_3) : NW'(n1_3);
      q1_4.neg <= n1_3[NW] ^ c3.neg_den;
      q2_4.num <= n2_3[NW] ? NW'(-n2_3) : NW'(n2_3);
      q2_4.neg <= (c3.rcase == qrs_pkg::CASE_COMPLEX) ? 1'b0 : (n2_3[NW] ^ c3.neg_den);
    end
  end

  // two restoring dividers: one quotient bit per stage
  logic          dvv [DV+1];
  ctx_t          dc  [DV+1];
  logic [NW-1:0] dn1 [DV+1], dn2 [DV+1];
  logic [DW-1:0] dr1 [DV+1], dr2 [DV+1];
  logic          ds1 [DV+1], ds2 [DV+1];
  assign dvv[0] = v4; assign dc[0] = c4;
  assign dn1[0] = q1_4.num; assign dn2[0] = q2_4.num;
  assign ds1[0] = q1_4.neg; assign ds2[0] = q2_4.neg;
  assign dr1[0] = '0; assign dr2[0] = '0;
  for (genvar g = 0; g < DV; g++) begin : g_div
    logic [DW:0] t1, t2;
    assign t1 = {dr1[g], dn1[g][NW-1]};
    assign t2 = {dr2[g], dn2[g][NW-1]};
    always_ff @(posedge clk) begin
      if (rst) dvv[g+1] <= 1'b0;
      else if (adv) dvv[g+1] <= dvv[g];
      if (adv) begin
        dc[g+1]  <= dc[g];
        ds1[g+1] <= ds1[g];
        ds2[g+1] <= ds2[g];
        if (t1 >= {1'b0, dc[g].den}) begin
          dr1[g+1] <= DW'(t1 - {1'b0, dc[g].den});
          dn1[g+1] <= {dn1[g][NW-2:0], 1'b1};
        end else begin
          dr1[g+1] <= DW'(t1);
          dn1[g+1] <= {dn1[g][NW-2:0], 1'b0};
        end
        if (t2 >= {1'b0, dc[g].den}) begin
          dr2[g+1] <= DW'(t2 - {1'b0, dc[g].den});
          dn2[g+1] <= {dn2[g][NW-2:0], 1'b1};
        end else begin
          dr2[g+1] <= DW'(t2);
          dn2[g+1] <= {dn2[g][NW-2:0], 1'b0};
        end
      end
    end
  end

  // output register: apply signs and zero the linear case
  logic [QW:0] f_w, s2_w;
  assign f_w  = ds1[DV] ? -{1'b0, dn1[DV]} : {1'b0, dn1[DV]};
  assign s2_w = ds2[DV] ? -{1'b0, dn2[DV]} : {1'b0, dn2[DV]};
  logic              ov;
  logic [1:0]        o_case;
  logic [DB-1:0]     o_disc;
  logic [VB-1:0]     o_first, o_second;
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= dvv[DV];
    if (adv) begin
      o_case <= dc[DV].rcase;
      o_disc <= DB'(dc[DV].disc);
      if (dc[DV].rcase == qrs_pkg::CASE_LINEAR) begin
        o_first  <= '0;
        o_second <= '0;
      end else begin
        o_first  <= VB'($signed(f_w));
        o_second <= VB'($signed(s2_w));
      end
    end
  end
  assign out_ch.valid = ov;
  assign out_ch.data  = {o_case, o_disc, o_first, o_second};

  `QRS_ASSERT_NEXT(a_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data), "stalled result changed")
  `QRS_ASSERT_IMPL(a_lin, clk, rst, out_ch.valid && o_case == qrs_pkg::CASE_LINEAR, o_first == '0 && o_second == '0, "linear case with nonzero roots")
  `QRS_ASSERT_IMPL(a_dbl, clk, rst, out_ch.valid && o_case == qrs_pkg::CASE_DOUBLE, o_first == o_second && o_disc == '0, "double root mismatch")
  `QRS_ASSERT_IMPL(a_cplx, clk, rst, out_ch.valid && o_case == qrs_pkg::CASE_COMPLEX, o_disc[DB-1] && !o_second[VB-1], "complex case sign error")
endmodule
`default_nettype wire

/* verif/tb_quadratic_root_solver_core.sv */
// Self-checking testbench for the quadratic root solver core.
`timescale 1ns / 1ps
`default_nettype none
module tb_quadratic_root_solver_core;
  localparam int CW       = qrs_pkg::COEF_WIDTH;
  localparam int FB       = qrs_pkg::FRAC_BITS;
  localparam int IN_W     = 3 * CW;
  localparam int OUT_W    = 2 + qrs_pkg::DISC_BITS + 2 * qrs_pkg::VAL_BITS;
  localparam int LATENCY  = 73;
  localparam int N_RANDOM = 1300;
  localparam int WDOG_MAX = 20000;

  typedef struct packed {
    qrs_pkg::root_case_t                  rcase;
    logic signed [qrs_pkg::DISC_BITS-1:0] disc;
    logic signed [qrs_pkg::VAL_BITS-1:0]  first;
    logic signed [qrs_pkg::VAL_BITS-1:0]  second;
  } roots_t;

  // Scaled integer square root: floor(sqrt(mag * 4^FRAC_BITS)), digit by digit.
  function automatic longint unsigned scaled_root(longint unsigned mag);
    longint unsigned rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int i = CW + FB; i >= 0; i--) begin
      pair = (i >= FB) ? ((mag >> (2 * (i - FB))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Solve one coefficient set; SV division truncates toward zero.
  function automatic roots_t solve_roots(logic [IN_W-1:0] coefs);
    longint a, b, c, d, nb, s, den, v1, v2;
    roots_t r;
    a = $signed(coefs[3*CW-1 -: CW]);
    b = $signed(coefs[2*CW-1 -: CW]);
    c = $signed(coefs[CW-1:0]);
    d = b * b - 4 * a * c;
    nb = -b * (longint'(1) << FB);
    v1 = 0;
    v2 = 0;
    if (a == 0) begin
      r.rcase = qrs_pkg::CASE_LINEAR;
    end else begin
      den = 2 * a;
      if (d > 0) begin
        s = longint'(scaled_root(d));
        r.rcase = qrs_pkg::CASE_TWO_REAL;
        v1 = (nb + s) / den;
        v2 = (nb - s) / den;
      end else if (d == 0) begin
        r.rcase = qrs_pkg::CASE_DOUBLE;
        v1 = nb / den;
        v2 = v1;
      end else begin
        s = longint'(scaled_root(-d));
        r.rcase = qrs_pkg::CASE_COMPLEX;
        v1 = nb / den;
        v2 = s / (den < 0 ? -den : den);
      end
    end
    r.disc = d[qrs_pkg::DISC_BITS-1:0];
    r.first = v1[qrs_pkg::VAL_BITS-1:0];
    r.second = v2[qrs_pkg::VAL_BITS-1:0];
    return r;
  endfunction

  class roots_scoreboard;
    roots_t pending_roots[$];
    int errors = 0;
    int checked = 0;
    int case_seen[4] = '{0, 0, 0, 0};

    function void note_coefs(logic [IN_W-1:0] coefs);
      pending_roots.push_back(solve_roots(coefs));
    endfunction

    function void check_roots(roots_t got);
      roots_t want;
      if (pending_roots.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, got);
        return;
      end
      want = pending_roots.pop_front();
      checked++;
      case_seen[want.rcase]++;
      if (got.rcase !== want.rcase) begin
        errors++;
        $display("%0t: root_case exp %0d act %0d", $time, want.rcase, got.rcase);
      end
      if (got.disc !== want.disc) begin
        errors++;
        $display("%0t: discriminant exp %0d act %0d", $time, want.disc, got.disc);
      end
      if (got.first !== want.first) begin
        errors++;
        $display("%0t: first_value exp %0d act %0d", $time, want.first, got.first);
      end
      if (got.second !== want.second) begin
        errors++;
        $display("%0t: second_value exp %0d act %0d", $time, want.second, got.second);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  qrs_stream_if #(.WIDTH(IN_W))  coef_ch ();
  qrs_stream_if #(.WIDTH(OUT_W)) roots_ch ();
  roots_scoreboard sb;
  int idle_cycles;
  bit all_sent;

  quadratic_root_solver_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (coef_ch.sink),
    .out_ch (roots_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted beats, check results, count idle cycles, stop on a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (coef_ch.valid && coef_ch.ready) sb.note_coefs(coef_ch.data);
      if (roots_ch.valid && roots_ch.ready) sb.check_roots(roots_t'(roots_ch.data));
      if ((coef_ch.valid && coef_ch.ready) || (roots_ch.valid && roots_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("%0t: watchdog: no beat accepted for %0d cycles", $time, idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stall the receiver on its own pattern: busy stretches, then free runs.
  initial begin
    int phase;
    roots_ch.ready = 1'b0;
    phase = 0;
    @(posedge clk iff !rst);
    forever begin
      phase++;
      if ((phase / 300) % 3 == 2)
        roots_ch.ready <= 1'b1;
      else
        roots_ch.ready <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
    end
  end

  // Present one coefficient beat, hold it until accepted.
  task automatic send_coefs(logic signed [CW-1:0] a,
                            logic signed [CW-1:0] b,
                            logic signed [CW-1:0] c);
    coef_ch.valid <= 1'b1;
    coef_ch.data <= {a, b, c};
    @(posedge clk);
    while (!coef_ch.ready) @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    coef_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random coefficient of a mostly small magnitude, sometimes full range.
  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 40)) - 20);
      2: return CW'(($urandom_range(0, 1) ? 32'h8000 : 32'h7fff) ^ $urandom_range(0, 3));
      default: return CW'($signed($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  initial begin
    logic signed [CW-1:0] a, b, k, r1, r2;
    int burst;
    sb = new();
    idle_cycles = 0;
    all_sent = 1'b0;
    rst = 1'b1;
    coef_ch.valid = 1'b0;
    coef_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, linear, double, complex, distinct real roots.
    send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_coefs(-16'sh8000, -16'sh8000, -16'sh8000);
    send_coefs(-16'sh8000, 16'sh7fff, 16'sh7fff);
    send_coefs(16'sh7fff, -16'sh8000, -16'sh8000);
    send_coefs(-16'sh8000, 0, 16'sh7fff);
    send_coefs(16'sh7fff, 0, -16'sh8000);
    send_coefs(0, 0, 0);
    send_coefs(0, -16'sh8000, 5);
    send_coefs(0, 16'sh7fff, -3);
    send_coefs(1, 2, 1);
    send_coefs(-1, 2, -1);
    send_coefs(3, 0, 0);
    send_coefs(1, 0, 1);
    send_coefs(-7, 3, -5);
    send_coefs(1, -3, 2);
    send_coefs(-2, 1, 3);
    send_coefs(1, 0, -2);
    send_coefs(16'sh5555, -16'sh2aab, 16'sh1234);
    pause_sender(3);

    // Random part in bursts with gaps.
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && n < N_RANDOM; j++, n++) begin
        case ($urandom_range(0, 9))
          0: begin
            // Double root: a(x-k)^2 with small a and k.
            a = CW'($signed($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 1 : -1));
            k = CW'($signed($urandom_range(0, 40)) - 20);
            send_coefs(a, CW'(-2 * a * k), CW'(a * k * k));
          end
          1: begin
            // Integer roots: a(x-r1)(x-r2).
            a = CW'($signed($urandom_range(1, 30)) * ($urandom_range(0, 1) ? 1 : -1));
            r1 = CW'($signed($urandom_range(0, 30)) - 15);
            r2 = CW'($signed($urandom_range(0, 30)) - 15);
            b = CW'(-a * (r1 + r2));
            send_coefs(a, b, CW'(a * r1 * r2));
          end
          2: send_coefs(0, rand_coef(), rand_coef());
          default: send_coefs(rand_coef(), rand_coef(), rand_coef());
        endcase
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    coef_ch.valid <= 1'b0;
    all_sent = 1'b1;
  end

  // Finish after drain, or on watchdog timeout.
  initial begin
    @(posedge clk iff all_sent);
    while (sb.pending_roots.size() != 0 && idle_cycles < WDOG_MAX) @(posedge clk);
    if (sb.pending_roots.size() != 0) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      repeat (2 * LATENCY) @(posedge clk);
      $display("Checked %0d result beats: %0d two-real, %0d double, %0d complex, %0d linear",
               sb.checked, sb.case_seen[0], sb.case_seen[1], sb.case_seen[2],
               sb.case_seen[3]);
      if (sb.errors == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
      $finish;
    end
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/qrs_pkg.sv
src/qrs_stream_if.sv
src/quadratic_root_solver_core.sv
verif/tb_quadratic_root_solver_core.sv
